// ===== design/lrast_pkg.sv =====
// Shared constants for the line rasterizer: field widths, opcodes, defaults.
`timescale 1ns / 1ps
package lrast_pkg;

  // Fixed widths of the stream fields
  localparam int FIELD_COORD_W = 12;
  localparam int COLOR_W       = 24;
  localparam int PEN_W         = 8;

  // Packed stream widths (input tdata is 4 coordinates, color and pen width)
  localparam int IN_TDATA_W  = 4 * FIELD_COORD_W + COLOR_W + PEN_W;
  localparam int OUT_TDATA_W = 2 * FIELD_COORD_W + COLOR_W + PEN_W;

  // Defaults for top-level parameters
  localparam int COORD_BITS_DEF  = 12;
  localparam int QUEUE_DEPTH_DEF = 4;

  // Opcodes carried in s_axis_tuser
  localparam logic OP_START = 1'b0;
  localparam logic OP_NEXT  = 1'b1;

endpackage

// ===== design/line_rasterizer_unit.sv =====
// Top level of the Bresenham line rasterizer: front end, command queue, stepper.
//
//  Channel  Dir  tdata (low bit up)                          tuser / tlast
//  s_axis   in   x_start, y_start, x_end, y_end, color, pen  tuser: opcode
//  m_axis   out  pixel_x, pixel_y, pixel_color, pixel_width  tuser: steep, tlast: last
//
// One transaction per clock is taken while the command queue has room, and one
// pixel per clock is given while m_axis_tready is high. A pixel's command is
// written into the command queue and then, on the way out, into the stepper's
// output register.
// s_axis_tready drops only when the command queue is full; the stepper
// stalls on m_axis_tready alone. Synchronous reset idles the line and empties
// the queue.
`timescale 1ns / 1ps
module line_rasterizer_unit #(
  parameter int COORD_BITS  = lrast_pkg::COORD_BITS_DEF,
  parameter int QUEUE_DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // x_start, y_start, x_end, y_end, pen_color, pen_width
  input  logic [lrast_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
  // opcode
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // pixel_x, pixel_y, pixel_color, pixel_width
  output logic [lrast_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
  // steep_line
  output logic [0:0]                         m_axis_tuser,
  output logic                               m_axis_tlast
);

  localparam int CW    = lrast_pkg::FIELD_COORD_W;
  localparam int CMD_W = 6 * COORD_BITS + 41;

  logic [CMD_W-1:0] front_cmd, queue_head;
  logic             queue_full, queue_empty, queue_pop;

  logic [CW-1:0]                 pixel_x, pixel_y;
  logic [lrast_pkg::COLOR_W-1:0] pixel_color;
  logic [lrast_pkg::PEN_W-1:0]   pixel_width;
  logic                          steep_line, last_pixel;

  lrast_front #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_front (
    .opcode    (s_axis_tuser[0]),
    .x_start   (s_axis_tdata[CW-1:0]),
    .y_start   (s_axis_tdata[2*CW-1:CW]),
    .x_end     (s_axis_tdata[3*CW-1:2*CW]),
    .y_end     (s_axis_tdata[4*CW-1:3*CW]),
    .pen_color (s_axis_tdata[4*CW+lrast_pkg::COLOR_W-1:4*CW]),
    .pen_width (s_axis_tdata[lrast_pkg::IN_TDATA_W-1:4*CW+lrast_pkg::COLOR_W]),
    .cmd       (front_cmd)
  );

  assign s_axis_tready = !queue_full;

  lrast_queue #(
    .WIDTH (CMD_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_data (front_cmd),
    .full      (queue_full),
    .pop       (queue_pop),
    .empty     (queue_empty),
    .head      (queue_head)
  );

  lrast_back #(
    .COORD_BITS (COORD_BITS),
    .CMD_W      (CMD_W)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cmd         (queue_head),
    .cmd_valid   (!queue_empty),
    .cmd_pop     (queue_pop),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .pixel_x     (pixel_x),
    .pixel_y     (pixel_y),
    .pixel_color (pixel_color),
    .pixel_width (pixel_width),
    .steep_line  (steep_line),
    .last_pixel  (last_pixel)
  );

  assign m_axis_tdata    = {pixel_width, pixel_color, pixel_y, pixel_x};
  assign m_axis_tuser[0] = steep_line;
  assign m_axis_tlast    = last_pixel;

endmodule

// ===== design/lrast_front.sv =====
// Front end: decodes an input transaction and sets up a line for the stepper.
`timescale 1ns / 1ps
module lrast_front #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 6 * COORD_BITS + 41
) (
  input  logic                                  opcode,
  input  logic [lrast_pkg::FIELD_COORD_W-1:0]   x_start,
  input  logic [lrast_pkg::FIELD_COORD_W-1:0]   y_start,
  input  logic [lrast_pkg::FIELD_COORD_W-1:0]   x_end,
  input  logic [lrast_pkg::FIELD_COORD_W-1:0]   y_end,
  input  logic [lrast_pkg::COLOR_W-1:0]         pen_color,
  input  logic [lrast_pkg::PEN_W-1:0]           pen_width,
  output logic [CMD_W-1:0]                      cmd
);

  localparam int ERR_W  = COORD_BITS + 4;
  localparam int STEP_W = COORD_BITS + 1;

  logic [COORD_BITS-1:0] xs, ys, xe, ye;
  logic [COORD_BITS-1:0] dx, dy, dmaj, dmin;
  logic [COORD_BITS-1:0] a0, a1, b0, b1;
  logic [COORD_BITS-1:0] major_pos, minor_pos, major_end;
  logic [ERR_W-1:0]      error_term;
  logic [STEP_W-1:0]     step_no_move, step_move;
  logic                  is_start, steep, minor_down;

  assign xs = COORD_BITS'(x_start);
  assign ys = COORD_BITS'(y_start);
  assign xe = COORD_BITS'(x_end);
  assign ye = COORD_BITS'(y_end);

  assign is_start = (opcode == lrast_pkg::OP_START);

  always_comb begin
    dx = (xe >= xs) ? (xe - xs) : (xs - xe);
    dy = (ye >= ys) ? (ye - ys) : (ys - ye);
    // Equal deltas stay row-major
    steep = (dx < dy);
    if (steep) begin
      a0 = ys; a1 = ye; b0 = xs; b1 = xe; dmaj = dy; dmin = dx;
    end else begin
      a0 = xs; a1 = xe; b0 = ys; b1 = ye; dmaj = dx; dmin = dy;
    end
    // Walk along the major axis in increasing order
    if (a0 > a1) begin
      major_pos  = a1;
      minor_pos  = b1;
      major_end  = a0;
      minor_down = (b1 > b0);
    end else begin
      major_pos  = a0;
      minor_pos  = b0;
      major_end  = a1;
      minor_down = (b0 > b1);
    end
    // Two's complement error term, sign taken from the MSB downstream
    error_term   = ERR_W'({dmin, 1'b0}) - ERR_W'(dmaj);
    step_no_move = {dmin, 1'b0};
    step_move    = {dmaj - dmin, 1'b0};
  end

  assign cmd = {is_start, steep, minor_down, major_pos, minor_pos, major_end,
                error_term, step_no_move, step_move, pen_color, pen_width};

endmodule

// ===== design/lrast_queue.sv =====
// Small register FIFO between the front end and the pixel stepper.
`timescale 1ns / 1ps
module lrast_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = lrast_pkg::QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] head
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entries [DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push, do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/lrast_back.sv =====
// Back end: holds the line state, steps the error term and registers pixels.
`timescale 1ns / 1ps
module lrast_back #(
  parameter int COORD_BITS = lrast_pkg::COORD_BITS_DEF,
  parameter int CMD_W      = 6 * COORD_BITS + 41
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [CMD_W-1:0]                      cmd,
  input  logic                                  cmd_valid,
  output logic                                  cmd_pop,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic [lrast_pkg::FIELD_COORD_W-1:0]   pixel_x,
  output logic [lrast_pkg::FIELD_COORD_W-1:0]   pixel_y,
  output logic [lrast_pkg::COLOR_W-1:0]         pixel_color,
  output logic [lrast_pkg::PEN_W-1:0]           pixel_width,
  output logic                                  steep_line,
  output logic                                  last_pixel
);

  localparam int ERR_W  = COORD_BITS + 4;
  localparam int STEP_W = COORD_BITS + 1;

  // Fields of the queued command
  logic                          c_start, c_steep, c_down;
  logic [COORD_BITS-1:0]         c_major, c_minor, c_end;
  logic [ERR_W-1:0]              c_err;
  logic [STEP_W-1:0]             c_snm, c_smv;
  logic [lrast_pkg::COLOR_W-1:0] c_color;
  logic [lrast_pkg::PEN_W-1:0]   c_width;

  assign {c_start, c_steep, c_down, c_major, c_minor, c_end,
          c_err, c_snm, c_smv, c_color, c_width} = cmd;

  // Line state
  logic                          active;
  logic                          is_steep, minor_down;
  logic [COORD_BITS-1:0]         major_pos, minor_pos, major_end;
  logic [ERR_W-1:0]              error_term;
  logic [STEP_W-1:0]             step_no_move, step_move;
  logic [lrast_pkg::COLOR_W-1:0] latched_color;
  logic [lrast_pkg::PEN_W-1:0]   latched_width;

  logic                          active_next, is_steep_next, minor_down_next;
  logic [COORD_BITS-1:0]         major_pos_next, minor_pos_next, major_end_next;
  logic [ERR_W-1:0]              error_term_next;
  logic [STEP_W-1:0]             step_no_move_next, step_move_next;
  logic [lrast_pkg::COLOR_W-1:0] latched_color_next;
  logic [lrast_pkg::PEN_W-1:0]   latched_width_next;
  logic                          emit;

  // Take a command whenever the output register is free or draining
  assign cmd_pop = cmd_valid && (!out_valid || out_ready);

  always_comb begin
    active_next        = active;
    is_steep_next      = is_steep;
    minor_down_next    = minor_down;
    major_pos_next     = major_pos;
    minor_pos_next     = minor_pos;
    major_end_next     = major_end;
    error_term_next    = error_term;
    step_no_move_next  = step_no_move;
    step_move_next     = step_move;
    latched_color_next = latched_color;
    latched_width_next = latched_width;
    emit               = 1'b0;
    if (cmd_pop) begin
      if (c_start) begin
        // A start drops any running line
        is_steep_next      = c_steep;
        minor_down_next    = c_down;
        major_pos_next     = c_major;
        minor_pos_next     = c_minor;
        major_end_next     = c_end;
        error_term_next    = c_err;
        step_no_move_next  = c_snm;
        step_move_next     = c_smv;
        latched_color_next = c_color;
        latched_width_next = c_width;
        emit               = 1'b1;
      end else if (active) begin
        major_pos_next = major_pos + 1'b1;
        if (error_term[ERR_W-1]) begin
          error_term_next = error_term + ERR_W'(step_no_move);
        end else begin
          minor_pos_next  = minor_down ? (minor_pos - 1'b1) : (minor_pos + 1'b1);
          error_term_next = error_term - ERR_W'(step_move);
        end
        emit = 1'b1;
      end
      // Next with no line running is dropped
      if (emit) begin
        active_next = (major_pos_next != major_end_next);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      active <= active_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    is_steep      <= is_steep_next;
    minor_down    <= minor_down_next;
    major_pos     <= major_pos_next;
    minor_pos     <= minor_pos_next;
    major_end     <= major_end_next;
    error_term    <= error_term_next;
    step_no_move  <= step_no_move_next;
    step_move     <= step_move_next;
    latched_color <= latched_color_next;
    latched_width <= latched_width_next;
    if (emit) begin
      pixel_x     <= lrast_pkg::FIELD_COORD_W'(is_steep_next ? minor_pos_next
                                                             : major_pos_next);
      pixel_y     <= lrast_pkg::FIELD_COORD_W'(is_steep_next ? major_pos_next
                                                             : minor_pos_next);
      pixel_color <= latched_color_next;
      pixel_width <= latched_width_next;
      steep_line  <= is_steep_next;
      last_pixel  <= (major_pos_next == major_end_next);
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for the Bresenham line rasterizer with a pixel scoreboard.
`timescale 1ns / 1ps
module testbench;

  localparam int IN_W        = lrast_pkg::IN_TDATA_W;
  localparam int OUT_W       = lrast_pkg::OUT_TDATA_W;
  localparam int STALL_PCT   = 19;
  localparam int STALL_LIMIT = 2000;
  localparam int ITEM_GOAL   = 1750;

  typedef struct packed {
    logic [11:0] x;
    logic [11:0] y;
    logic [23:0] color;
    logic [7:0]  width;
    logic        steep;
    logic        last;
  } pixel_t;

  class pixel_scoreboard;
    logic [11:0]        major_pos, minor_pos, major_end;
    logic signed [15:0] err_term, stay_step, diag_step;
    logic               minor_dec, steep, busy;
    logic [23:0]        color;
    logic [7:0]         width;
    pixel_t             pixel_q[$];
    int                 errors;

    function new();
      major_pos = '0; minor_pos = '0; major_end = '0;
      err_term  = '0; stay_step = '0; diag_step = '0;
      minor_dec = 1'b0; steep = 1'b0; busy = 1'b0;
      color = '0; width = '0; errors = 0;
    endfunction

    function int pending();
      return pixel_q.size();
    endfunction

    // Returns 1 when the transaction produces a pixel.
    function bit note_input(logic op, logic [IN_W-1:0] data);
      logic [11:0] xs, ys, xe, ye, dx, dy, a0, a1, b0, b1;
      int          dmaj, dmin;
      pixel_t      px;
      if (op == lrast_pkg::OP_START) begin
        xs = data[11:0];
        ys = data[23:12];
        xe = data[35:24];
        ye = data[47:36];
        dx = (xe >= xs) ? xe - xs : xs - xe;
        dy = (ye >= ys) ? ye - ys : ys - ye;
        steep = dx < dy;
        if (steep) begin
          a0 = ys; a1 = ye; b0 = xs; b1 = xe; dmaj = dy; dmin = dx;
        end else begin
          a0 = xs; a1 = xe; b0 = ys; b1 = ye; dmaj = dx; dmin = dy;
        end
        err_term  = 16'(2 * dmin - dmaj);
        stay_step = 16'(2 * dmin);
        diag_step = 16'(2 * (dmaj - dmin));
        // walk along the major axis in increasing order
        if (a0 > a1) begin
          major_pos = a1; minor_pos = b1; major_end = a0; minor_dec = b1 > b0;
        end else begin
          major_pos = a0; minor_pos = b0; major_end = a1; minor_dec = b0 > b1;
        end
        color = data[71:48];
        width = data[79:72];
      end else begin
        if (!busy) return 1'b0;
        major_pos = major_pos + 12'd1;
        if (err_term < 0) begin
          err_term = err_term + stay_step;
        end else begin
          minor_pos = minor_dec ? minor_pos - 12'd1 : minor_pos + 12'd1;
          err_term  = err_term - diag_step;
        end
      end
      px.x     = steep ? minor_pos : major_pos;
      px.y     = steep ? major_pos : minor_pos;
      px.color = color;
      px.width = width;
      px.steep = steep;
      px.last  = major_pos == major_end;
      pixel_q.push_back(px);
      busy = major_pos != major_end;
      return 1'b1;
    endfunction

    function void check(logic [OUT_W-1:0] data, logic steep_f, logic last_f);
      pixel_t got, want;
      got = {data[11:0], data[23:12], data[47:24], data[55:48], steep_f, last_f};
      if (pixel_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel, expected none, actual %h", $time, got);
        return;
      end
      want = pixel_q.pop_front();
      if (got.x !== want.x) mismatch("pixel_x", want.x, got.x);
      if (got.y !== want.y) mismatch("pixel_y", want.y, got.y);
      if (got.color !== want.color) mismatch("pixel_color", want.color, got.color);
      if (got.width !== want.width) mismatch("pixel_width", want.width, got.width);
      if (got.steep !== want.steep) mismatch("steep_line", want.steep, got.steep);
      if (got.last !== want.last) mismatch("last_pixel", want.last, got.last);
    endfunction

    function void mismatch(string field, logic [23:0] want, logic [23:0] got);
      errors++;
      $display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_axis_tvalid = 1'b0;
  logic             s_axis_tready;
  logic [IN_W-1:0]  s_axis_tdata = '0;
  logic [0:0]       s_axis_tuser = lrast_pkg::OP_START;
  logic             m_axis_tvalid;
  logic             m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;
  logic [0:0]       m_axis_tuser;
  logic             m_axis_tlast;

  pixel_scoreboard sb;
  bit              quiet = 1'b0;
  int              pixels_due = 0;
  int              stall_cycles = 0;

  line_rasterizer_unit dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    m_axis_tready <= quiet || ($urandom_range(99) >= STALL_PCT);
  end

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
  end

  // End the run when neither side moves for too long.
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
      $display("Regression FAIL");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic logic [IN_W-1:0] start_word(logic [11:0] xs, logic [11:0] ys,
                                                 logic [11:0] xe, logic [11:0] ye,
                                                 logic [23:0] col, logic [7:0] w);
    return {w, col, ye, xe, ys, xs};
  endfunction

  function automatic logic [IN_W-1:0] noise_word();
    return {16'($urandom), $urandom, $urandom};
  endfunction

  function automatic int line_length(logic [IN_W-1:0] data);
    int dx, dy;
    dx = int'(data[35:24]) - int'(data[11:0]);
    dy = int'(data[47:36]) - int'(data[23:12]);
    if (dx < 0) dx = -dx;
    if (dy < 0) dy = -dy;
    return (dx > dy) ? dx : dy;
  endfunction

  task automatic send_item(input logic op, input logic [IN_W-1:0] data);
    while (!quiet && $urandom_range(99) < STALL_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid   <= 1'b1;
    s_axis_tuser[0] <= op;
    s_axis_tdata    <= data;
    do @(posedge clk); while (!s_axis_tready);
    pixels_due += sb.note_input(op, data);
  endtask

  task automatic send_next(input int count);
    repeat (count) send_item(lrast_pkg::OP_NEXT, noise_word());
  endtask

  // Hold the sender until every pixel owed has arrived.
  task automatic drain_pixels();
    s_axis_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic pick_pair(input int span, output logic [11:0] a, output logic [11:0] b);
    int base, d;
    base = $urandom_range(4095);
    d    = $urandom_range(span);
    if (base + d <= 4095 && ($urandom_range(1) == 1 || base < d)) b = 12'(base + d);
    else if (base >= d) b = 12'(base - d);
    else b = 12'($urandom_range(4095));
    a = 12'(base);
  endtask

  initial begin
    logic [11:0]     xs, ys, xe, ye;
    logic [IN_W-1:0] word;
    int              span, len, nexts, pick;
    bit              paused;
    sb = new();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // next while idle, zero-length line, then next after it
    send_next(1);
    send_item(lrast_pkg::OP_START,
              start_word(12'd5, 12'd5, 12'd5, 12'd5, 24'hFFFFFF, 8'hFF));
    send_next(1);
    // equal deltas across the whole range, cut short by a reversed shallow line
    send_item(lrast_pkg::OP_START,
              start_word(12'd0, 12'd0, 12'd4095, 12'd4095, 24'h0, 8'h0));
    send_next(2);
    send_item(lrast_pkg::OP_START,
              start_word(12'd4095, 12'd0, 12'd0, 12'd3, 24'h123456, 8'h01));
    send_next(2);
    // steep line with decreasing minor axis, run to the end and past it
    send_item(lrast_pkg::OP_START,
              start_word(12'd3, 12'd0, 12'd1, 12'd4, 24'hA5A5A5, 8'h80));
    send_next(5);
    // vertical line given top-down, then a horizontal line given right to left
    send_item(lrast_pkg::OP_START,
              start_word(12'd0, 12'd4095, 12'd0, 12'd0, 24'h800001, 8'h7F));
    send_next(2);
    send_item(lrast_pkg::OP_START,
              start_word(12'd4095, 12'd4095, 12'd4093, 12'd4095, 24'h5A5A5A, 8'hC3));
    send_next(3);
    drain_pixels();

    pixels_due = 0;
    paused = 1'b0;
    while (pixels_due < ITEM_GOAL) begin
      quiet = (pixels_due >= 700 && pixels_due < 1000);
      if (!paused && pixels_due >= 1200) begin
        drain_pixels();
        paused = 1'b1;
      end
      pick = $urandom_range(99);
      if (pick < 5) begin
        send_next(1);
      end else begin
        span = (pick < 80) ? 12 : (pick < 95) ? 60 : (pick < 99) ? 400 : 4095;
        pick_pair(span, xs, xe);
        pick_pair(span, ys, ye);
        word = start_word(xs, ys, xe, ye, 24'($urandom), 8'($urandom));
        len  = line_length(word);
        pick = $urandom_range(99);
        if (pick < 70) nexts = len;
        else if (pick < 85) nexts = len + $urandom_range(1, 3);
        else nexts = $urandom_range(len);
        if (span == 4095 && nexts > 40) nexts = $urandom_range(40);
        send_item(lrast_pkg::OP_START, word);
        send_next(nexts);
      end
    end
    quiet = 1'b0;

    drain_pixels();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
design/lrast_pkg.sv
design/lrast_front.sv
design/lrast_queue.sv
design/lrast_back.sv
design/line_rasterizer_unit.sv
test/testbench.sv
